// ===== rtl/rsps_pkg.sv =====
// shared types and constants of the record store packet server
// no dependencies; used by every module of the block

package rsps_pkg;

	localparam int SLOTS_DEF     = 64;
	localparam int NBR_SLOTS_DEF = 32;

	localparam int REC_BYTES   = 20;
	localparam int REC_W_LOW   = 64;
	localparam int REC_W_MID   = 64;
	localparam int REC_W_HIGH  = 24;
	localparam int REC_W       = REC_W_LOW + REC_W_MID + REC_W_HIGH;
	localparam int NKW         = 6;
	localparam int MAX_NODE    = 25;

	// input modes
	localparam logic [1:0] MODE_PKT       = 2'd0;
	localparam logic [1:0] MODE_CLR_STORE = 2'd1;
	localparam logic [1:0] MODE_CLR_NBR   = 2'd2;

	// message types
	localparam logic [7:0] MSG_DISCOVER   = 8'h00;
	localparam logic [7:0] MSG_DISC_ANS   = 8'h01;
	localparam logic [7:0] MSG_CREATE     = 8'h02;
	localparam logic [7:0] MSG_DELETE     = 8'h03;
	localparam logic [7:0] MSG_RETRIEVE   = 8'h04;

	// reply kinds and status codes
	localparam logic KIND_DISC_ANS = 1'b0;
	localparam logic KIND_STATUS   = 1'b1;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_DEL_FAIL = 2'd2;
	localparam logic [1:0] STAT_GET_FAIL = 2'd3;

	// register index, taken from paddr[2]
	localparam logic REG_GROUP = 1'b0;
	localparam logic REG_NODE  = 1'b1;

	typedef struct packed {
		logic       rd_en;
		logic [7:0] rd_idx;
		logic       wr_en;
		logic       release_en;
		logic [7:0] rel_idx;
		logic       clear;
	} st_cmd_t;

	typedef struct packed {
		logic lookup;
		logic add;
		logic clear;
	} nb_cmd_t;

endpackage

// ===== rtl/rsps_store.sv =====
// record store: slot memory with registered read, valid bits and lowest free slot
// depends on rsps_pkg

module rsps_store import rsps_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  st_cmd_t          cmd,
	input  logic [REC_W-1:0] wr_data,
	output logic [REC_W-1:0] rd_data,
	output logic             rd_used,
	output logic             free_found,
	output logic             free_ok_unused
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [REC_W-1:0] mem [SLOTS];
	logic [REC_W-1:0] rd_q;
	logic [SLOTS-1:0] used_q;
	logic             rd_used_q;
	logic [SW-1:0]    free_idx_q;
	logic             free_found_q;
	logic [SW-1:0]    free_idx;
	logic             rd_in_range;

	// lowest free slot, registered; the used bits settle before it is needed
	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = SW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_idx_q   <= '0;
			free_found_q <= 1'b0;
		end else begin
			free_idx_q   <= free_idx;
			free_found_q <= ~&used_q;
		end
	end

	assign rd_in_range = cmd.rd_idx < 8'(SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			rd_used_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				used_q <= '0;
			end else begin
				if (cmd.wr_en && free_found_q) begin
					used_q[free_idx_q] <= 1'b1;
				end
				if (cmd.release_en) begin
					used_q[cmd.rel_idx[SW-1:0]] <= 1'b0;
				end
			end
			if (cmd.rd_en) begin
				rd_used_q <= rd_in_range && used_q[cmd.rd_idx[SW-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && free_found_q) begin
			mem[free_idx_q] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[cmd.rd_idx[SW-1:0]];
		end
	end

	assign rd_data        = rd_q;
	assign rd_used        = rd_used_q;
	assign free_found     = free_found_q;
	assign free_ok_unused = free_found_q && !used_q[free_idx_q];

endmodule

// ===== rtl/rsps_nbr.sv =====
// neighbor list: deduplicated sender ids with a registered lookup
// depends on rsps_pkg

module rsps_nbr import rsps_pkg::*; #(
	parameter int NEIGHBOR_SLOTS = NBR_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  nb_cmd_t        cmd,
	input  logic [7:0]     lookup_key,
	input  logic [7:0]     add_key,
	output logic [NKW-1:0] count
);

	localparam int NW  = $clog2(NEIGHBOR_SLOTS + 1);
	localparam int NIW = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;

	logic [7:0]          ids_q [NEIGHBOR_SLOTS];
	logic [NW-1:0]       total_q;
	logic                hit_q;
	logic [NEIGHBOR_SLOTS-1:0] match;

	always_comb begin
		for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
			match[i] = (NW'(i) < total_q) && (ids_q[i] == lookup_key);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (cmd.lookup) begin
				hit_q <= |match;
			end
			if (cmd.clear) begin
				total_q <= '0;
			end else if (cmd.add && !hit_q && total_q < NW'(NEIGHBOR_SLOTS)) begin
				total_q <= total_q + NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add && !cmd.clear && !hit_q && total_q < NW'(NEIGHBOR_SLOTS)) begin
			ids_q[total_q[NIW-1:0]] <= add_key;
		end
	end

	assign count = NKW'(total_q);

endmodule

// ===== rtl/record_store_packet_server_top.sv =====
// record store packet server: top level with item handshake, register port and control
// depends on rsps_pkg, rsps_store, rsps_nbr
//
// input channel (in_valid/in_ready) takes one decoded packet header or local
// command per item; output channel (out_valid/out_ready) returns at most one
// reply item per input item, in order.
// an item is accepted in the idle state: that edge reads the slot memory at
// slot_index and looks the sender up in the neighbor list. the edge that
// commits the item in execute decides, writes the slot memory, valid bits or
// neighbor list and loads the output register. the slot memory read is
// registered, so the next item is taken only after the block has returned
// to idle.
// the output register holds one reply; a new item is accepted while it
// waits, but if that item has a reply it stays in execute until out_ready
// frees the register.
// reset empties the record store and neighbor list, sets group_id and
// own_node to 1 and takes effect at once; no clearing pass is needed.
// registers: group_id at byte address 0, own_node at byte address 4.

module record_store_packet_server_top import rsps_pkg::*; #(
	parameter int SLOTS          = SLOTS_DEF,
	parameter int NEIGHBOR_SLOTS = NBR_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [15:0]           packet_group,
	input  logic [7:0]            message_type,
	input  logic [7:0]            request_number,
	input  logic [7:0]            sender,
	input  logic [7:0]            receiver,
	input  logic [7:0]            slot_index,
	input  logic [REC_W_LOW-1:0]  data_low,
	input  logic [REC_W_MID-1:0]  data_middle,
	input  logic [REC_W_HIGH-1:0] data_high,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  reply_kind,
	output logic [7:0]            reply_request,
	output logic [7:0]            reply_target,
	output logic [1:0]            status,
	output logic [REC_W_LOW-1:0]  reply_low,
	output logic [REC_W_MID-1:0]  reply_middle,
	output logic [REC_W_HIGH-1:0] reply_high,
	output logic [NKW-1:0]        neighbors_known
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic [15:0] group_q;
	logic [4:0]  node_q;

	logic [1:0]       mode_s1;
	logic [15:0]      grp_s1;
	logic [7:0]       type_s1;
	logic [7:0]       req_s1;
	logic [7:0]       snd_s1;
	logic [7:0]       rcv_s1;
	logic [7:0]       idx_s1;
	logic [REC_W-1:0] data_s1;

	logic                  out_valid_q;
	logic                  kind_q;
	logic [7:0]            req_q;
	logic [7:0]            target_q;
	logic [1:0]            status_q;
	logic [REC_W_LOW-1:0]  low_q;
	logic [REC_W_MID-1:0]  mid_q;
	logic [REC_W_HIGH-1:0] high_q;
	logic [NKW-1:0]        known_q;

	st_cmd_t          st_cmd;
	nb_cmd_t          nb_cmd;
	logic [REC_W-1:0] rd_data;
	logic             rd_used;
	logic             free_found;
	logic             free_ok;
	logic [NKW-1:0]   nb_count;

	logic       accept;
	logic       commit;
	logic       has_res;
	logic       res_kind;
	logic [1:0] res_status;
	logic       res_data;
	logic       ours;
	logic       grp_ok;
	logic       idx_ok;
	logic       do_create;
	logic       do_release;
	logic       do_add;

	// register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= 16'd1;
			node_q  <= 5'd1;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_GROUP: group_q <= pwdata[15:0];
				REG_NODE:  node_q  <= pwdata[4:0];
				default:   group_q <= group_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_GROUP: prdata = {16'd0, group_q};
			REG_NODE:  prdata = {27'd0, node_q};
			default:   prdata = '0;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			grp_s1  <= packet_group;
			type_s1 <= message_type;
			req_s1  <= request_number;
			snd_s1  <= sender;
			rcv_s1  <= receiver;
			idx_s1  <= slot_index;
			data_s1 <= {data_high, data_middle, data_low};
		end
	end

	// decide on the item held in the _s1 registers
	assign grp_ok = (grp_s1 == group_q);
	assign ours   = grp_ok && (rcv_s1 == {3'd0, node_q});
	assign idx_ok = (idx_s1 < 8'(SLOTS)) && rd_used;

	always_comb begin
		has_res    = 1'b0;
		res_kind   = KIND_STATUS;
		res_status = STAT_OK;
		res_data   = 1'b0;
		do_create  = 1'b0;
		do_release = 1'b0;
		do_add     = 1'b0;
		if (mode_s1 == MODE_PKT) begin
			case (type_s1)
				MSG_DISCOVER: begin
					has_res  = grp_ok;
					res_kind = KIND_DISC_ANS;
				end
				MSG_DISC_ANS: begin
					do_add = ours;
				end
				MSG_CREATE: begin
					has_res    = ours;
					do_create  = ours && free_found;
					res_status = free_found ? STAT_OK : STAT_FULL;
				end
				MSG_DELETE: begin
					has_res    = ours;
					do_release = ours && idx_ok;
					res_status = idx_ok ? STAT_OK : STAT_DEL_FAIL;
				end
				MSG_RETRIEVE: begin
					has_res    = ours;
					res_data   = idx_ok;
					res_status = idx_ok ? STAT_OK : STAT_GET_FAIL;
				end
				default: has_res = 1'b0;
			endcase
		end
	end

	// interlock: hold an item with a reply while the output register is still full and out_ready is low
	assign commit = (state_q == ST_EXEC) && !(has_res && out_valid_q && !out_ready);

	always_comb begin
		st_cmd.rd_en      = accept;
		st_cmd.rd_idx     = slot_index;
		st_cmd.wr_en      = commit && do_create && free_ok;
		st_cmd.release_en = commit && do_release;
		st_cmd.rel_idx    = idx_s1;
		st_cmd.clear      = commit && (mode_s1 == MODE_CLR_STORE);
		nb_cmd.lookup     = accept;
		nb_cmd.add        = commit && do_add;
		nb_cmd.clear      = commit && (mode_s1 == MODE_CLR_NBR);
	end

	rsps_store #(
		.SLOTS(SLOTS)
	) u_store (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (st_cmd),
		.wr_data        (data_s1),
		.rd_data        (rd_data),
		.rd_used        (rd_used),
		.free_found     (free_found),
		.free_ok_unused (free_ok)
	);

	rsps_nbr #(
		.NEIGHBOR_SLOTS(NEIGHBOR_SLOTS)
	) u_nbr (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (nb_cmd),
		.lookup_key (sender),
		.add_key    (snd_s1),
		.count      (nb_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit && has_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && has_res) begin
			kind_q   <= res_kind;
			req_q    <= req_s1;
			target_q <= snd_s1;
			status_q <= res_status;
			// last record byte is never stored, so the high word holds bytes 16 to 18
			low_q    <= res_data ? rd_data[REC_W_LOW-1:0] : '0;
			mid_q    <= res_data ? rd_data[REC_W_LOW +: REC_W_MID] : '0;
			high_q   <= res_data ? rd_data[REC_W_LOW + REC_W_MID +: REC_W_HIGH] : '0;
			known_q  <= nb_count;
		end
	end

	assign out_valid       = out_valid_q;
	assign reply_kind      = kind_q;
	assign reply_request   = req_q;
	assign reply_target    = target_q;
	assign status          = status_q;
	assign reply_low       = low_q;
	assign reply_middle    = mid_q;
	assign reply_high      = high_q;
	assign neighbors_known = known_q;

endmodule

// ===== rtl/rsps_checker.sv =====
// port-level checks of the record store packet server, bound to the top level
// depends on rsps_pkg and record_store_packet_server_top

module rsps_checker import rsps_pkg::*; #(
	parameter int NEIGHBOR_SLOTS = NBR_SLOTS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  reply_kind,
	input logic [7:0]            reply_request,
	input logic [1:0]            status,
	input logic [REC_W_LOW-1:0]  reply_low,
	input logic [REC_W_MID-1:0]  reply_middle,
	input logic [REC_W_HIGH-1:0] reply_high,
	input logic [NKW-1:0]        neighbors_known
);

	// a waiting reply holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reply_request) && $stable(status)
			&& $stable(reply_low) && $stable(neighbors_known))
		else $error("stalled reply changed");

	// an accepted item holds in_ready low while it is in execute
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted in consecutive cycles");

	a_disc_answer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_kind == KIND_DISC_ANS |-> status == STAT_OK)
		else $error("discovery answer with error status");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_OK || reply_kind == KIND_DISC_ANS)
			|-> reply_low == '0 && reply_middle == '0 && reply_high == '0)
		else $error("record data in a reply that carries none");

	a_nbr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> neighbors_known <= NKW'(NEIGHBOR_SLOTS))
		else $error("neighbor count beyond list size");

endmodule

bind record_store_packet_server_top rsps_checker #(
	.NEIGHBOR_SLOTS(NEIGHBOR_SLOTS)
) u_rsps_checker (.*);

// ===== bench/tb_record_store_packet_server_top.sv =====
// testbench for record_store_packet_server_top: directed and random packets, shadow
// prediction of replies, random stalls on both channels; depends on rsps_pkg and the rtl

module tb_record_store_packet_server_top;
	import rsps_pkg::*;

	localparam int NSLOT         = SLOTS_DEF;
	localparam int NNBR          = NBR_SLOTS_DEF;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int CHOKE_CYCLES  = 400;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_ITEMS   = 175;

	localparam logic [1:0] MODE_UNUSED       = 2'd3;
	localparam logic [7:0] MSG_FIRST_UNKNOWN = MSG_RETRIEVE + 8'd1;
	localparam logic [7:0] MSG_LAST_UNKNOWN  = 8'hFF;

	typedef struct {
		logic [1:0]  mode;
		logic [15:0] pkt_group;
		logic [7:0]  msg;
		logic [7:0]  req;
		logic [7:0]  src;
		logic [7:0]  dst;
		logic [7:0]  idx;
		logic [63:0] lo;
		logic [63:0] mid;
		logic [23:0] hi;
	} packet_t;

	typedef struct {
		logic        kind;
		logic [7:0]  req;
		logic [7:0]  target;
		logic [1:0]  stat;
		logic [63:0] lo;
		logic [63:0] mid;
		logic [23:0] hi;
		logic [5:0]  known;
	} reply_t;

	class record_server_shadow;
		logic [15:0] group_id;
		logic [4:0]  own_node;
		bit          slot_used [NSLOT];
		logic [63:0] slot_low [NSLOT];
		logic [63:0] slot_mid [NSLOT];
		logic [23:0] slot_high [NSLOT];
		logic [7:0]  neighbor_id [NNBR];
		int          neighbor_cnt;
		reply_t      replies_due [$];
		int          mismatches;

		function new();
			group_id = 16'd1;
			own_node = 5'd1;
			neighbor_cnt = 0;
			mismatches = 0;
			foreach (slot_used[i]) slot_used[i] = 1'b0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task compare(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("%s is %0h, expected %0h", name, got, want));
		endtask

		function void push_reply(logic kind, packet_t p, logic [1:0] stat, logic [63:0] lo,
				logic [63:0] mid, logic [23:0] hi);
			reply_t r;
			r.kind = kind;
			r.req = p.req;
			r.target = p.src;
			r.stat = stat;
			r.lo = lo;
			r.mid = mid;
			r.hi = hi;
			r.known = neighbor_cnt[5:0];
			replies_due.push_back(r);
		endfunction

		function void take_packet(packet_t p);
			bit ours;
			int free_slot;
			bit seen;
			ours = (p.pkt_group == group_id) && (p.dst == {3'b000, own_node});
			free_slot = -1;
			seen = 1'b0;
			if (p.mode == MODE_CLR_STORE) begin
				foreach (slot_used[i]) slot_used[i] = 1'b0;
				return;
			end
			if (p.mode == MODE_CLR_NBR) begin
				neighbor_cnt = 0;
				return;
			end
			if (p.mode != MODE_PKT)
				return;
			case (p.msg)
			MSG_DISCOVER: begin
				// the receiver is not checked here
				if (p.pkt_group == group_id)
					push_reply(KIND_DISC_ANS, p, STAT_OK, '0, '0, '0);
			end
			MSG_DISC_ANS: begin
				if (ours) begin
					for (int i = 0; i < neighbor_cnt; i++)
						if (neighbor_id[i] == p.src)
							seen = 1'b1;
					if (!seen && neighbor_cnt < NNBR) begin
						neighbor_id[neighbor_cnt] = p.src;
						neighbor_cnt++;
					end
				end
			end
			MSG_CREATE: begin
				if (ours) begin
					for (int i = NSLOT - 1; i >= 0; i--)
						if (!slot_used[i])
							free_slot = i;
					if (free_slot < 0) begin
						push_reply(KIND_STATUS, p, STAT_FULL, '0, '0, '0);
					end else begin
						slot_used[free_slot] = 1'b1;
						slot_low[free_slot] = p.lo;
						slot_mid[free_slot] = p.mid;
						slot_high[free_slot] = p.hi;
						push_reply(KIND_STATUS, p, STAT_OK, '0, '0, '0);
					end
				end
			end
			MSG_DELETE: begin
				if (ours) begin
					if (p.idx >= NSLOT || !slot_used[p.idx]) begin
						push_reply(KIND_STATUS, p, STAT_DEL_FAIL, '0, '0, '0);
					end else begin
						slot_used[p.idx] = 1'b0;
						push_reply(KIND_STATUS, p, STAT_OK, '0, '0, '0);
					end
				end
			end
			MSG_RETRIEVE: begin
				if (ours) begin
					if (p.idx >= NSLOT || !slot_used[p.idx])
						push_reply(KIND_STATUS, p, STAT_GET_FAIL, '0, '0, '0);
					else
						push_reply(KIND_STATUS, p, STAT_OK, slot_low[p.idx],
							slot_mid[p.idx], slot_high[p.idx]);
				end
			end
			default: ;
			endcase
		endfunction

		task check_reply(reply_t got);
			reply_t want;
			if (replies_due.size() == 0) begin
				report($sformatf("reply to node %0d with no item waiting", got.target));
				return;
			end
			want = replies_due.pop_front();
			compare("reply_kind", 64'(got.kind), 64'(want.kind));
			compare("reply_request", 64'(got.req), 64'(want.req));
			compare("reply_target", 64'(got.target), 64'(want.target));
			compare("status", 64'(got.stat), 64'(want.stat));
			compare("reply_low", got.lo, want.lo);
			compare("reply_middle", got.mid, want.mid);
			compare("reply_high", 64'(got.hi), 64'(want.hi));
			compare("neighbors_known", 64'(got.known), 64'(want.known));
		endtask

		function int pending();
			return replies_due.size();
		endfunction

		function int pick_used_slot();
			int cand [$];
			foreach (slot_used[i])
				if (slot_used[i])
					cand.push_back(i);
			if (cand.size() == 0)
				return $urandom_range(0, NSLOT - 1);
			return cand[$urandom_range(0, cand.size() - 1)];
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = '0;
	logic [15:0] packet_group = '0;
	logic [7:0]  message_type = '0;
	logic [7:0]  request_number = '0;
	logic [7:0]  sender = '0;
	logic [7:0]  receiver = '0;
	logic [7:0]  slot_index = '0;
	logic [63:0] data_low = '0;
	logic [63:0] data_middle = '0;
	logic [23:0] data_high = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        reply_kind;
	logic [7:0]  reply_request;
	logic [7:0]  reply_target;
	logic [1:0]  status;
	logic [63:0] reply_low;
	logic [63:0] reply_middle;
	logic [23:0] reply_high;
	logic [5:0]  neighbors_known;

	record_server_shadow shadow;
	bit calm = 1'b0;
	bit choke_req = 1'b0;
	int cycles = 0;

	record_store_packet_server_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// watch both channels; inputs are noted before replies are checked
	always @(posedge clk) begin : watch
		packet_t seen;
		reply_t got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen.mode = mode;
				seen.pkt_group = packet_group;
				seen.msg = message_type;
				seen.req = request_number;
				seen.src = sender;
				seen.dst = receiver;
				seen.idx = slot_index;
				seen.lo = data_low;
				seen.mid = data_middle;
				seen.hi = data_high;
				shadow.take_packet(seen);
			end
			if (out_valid && out_ready) begin
				got.kind = reply_kind;
				got.req = reply_request;
				got.target = reply_target;
				got.stat = status;
				got.lo = reply_low;
				got.mid = reply_middle;
				got.hi = reply_high;
				got.known = neighbors_known;
				shadow.check_reply(got);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// reply side: random stalls, plus one long hold-off on request
	initial begin : receiver_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (choke_req) begin
				out_ready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
				choke_req = 1'b0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	function automatic packet_t make_pkt(logic [1:0] md, logic [15:0] grp, logic [7:0] msg,
			logic [7:0] src, logic [7:0] dst, logic [7:0] idx);
		packet_t p;
		p.mode = md;
		p.pkt_group = grp;
		p.msg = msg;
		p.req = 8'($urandom);
		p.src = src;
		p.dst = dst;
		p.idx = idx;
		p.lo = {$urandom, $urandom};
		p.mid = {$urandom, $urandom};
		p.hi = 24'($urandom);
		return p;
	endfunction

	function automatic packet_t random_pkt(bit clears, bit fill);
		packet_t p;
		int r;
		int q;
		int idx;
		logic [15:0] grp;
		logic [7:0] node;
		r = $urandom_range(0, 99);
		q = $urandom_range(0, 9);
		grp = shadow.group_id;
		node = {3'b000, shadow.own_node};
		if (q < 6)
			idx = shadow.pick_used_slot();
		else if (q < 9)
			idx = $urandom_range(0, NSLOT - 1);
		else
			idx = $urandom_range(NSLOT, 255);
		p = make_pkt(MODE_PKT, grp, MSG_CREATE, 8'($urandom), node, 8'(idx));
		if (clears && r < 2) begin
			p.mode = (r == 0) ? MODE_CLR_STORE : MODE_CLR_NBR;
		end else if (r < 4) begin
			p.mode = MODE_UNUSED;
			p.msg = 8'($urandom);
			p.pkt_group = 16'($urandom);
			p.dst = 8'($urandom);
		end else if (r < 8) begin
			p.msg = 8'($urandom_range(MSG_FIRST_UNKNOWN, MSG_LAST_UNKNOWN));
		end else if (r < 14) begin
			// command for someone else: one bit off in group or receiver
			p.msg = MSG_CREATE + 8'($urandom_range(0, 2));
			if ($urandom_range(0, 1))
				p.pkt_group = grp ^ (16'd1 << $urandom_range(0, 15));
			else
				p.dst = node ^ (8'd1 << $urandom_range(0, 7));
		end else if (fill && r < 36) begin
			// random senders so the neighbor list fills up
			p.msg = MSG_DISC_ANS;
			p.src = 8'($urandom);
		end else if (r < 24) begin
			p.msg = MSG_DISCOVER;
			p.dst = 8'($urandom);
			if ($urandom_range(0, 9) == 0)
				p.pkt_group = 16'($urandom);
		end else if (r < 36) begin
			p.msg = MSG_DISC_ANS;
			p.src = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 47));
			if ($urandom_range(0, 4) == 0)
				p.dst = 8'($urandom);
		end else if (r < 70 || (fill && r < 82)) begin
			p.msg = MSG_CREATE;
		end else if (r < 82) begin
			p.msg = MSG_DELETE;
		end else begin
			p.msg = MSG_RETRIEVE;
		end
		return p;
	endfunction

	task automatic send_item(packet_t p);
		int gap;
		mode <= p.mode;
		packet_group <= p.pkt_group;
		message_type <= p.msg;
		request_number <= p.req;
		sender <= p.src;
		receiver <= p.dst;
		slot_index <= p.idx;
		data_low <= p.lo;
		data_middle <= p.mid;
		data_high <= p.hi;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (shadow.pending() != 0) @(posedge clk);
		// items without a reply may still be in the pipeline
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic regsel, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {regsel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (regsel == REG_GROUP)
			shadow.group_id = value[15:0];
		else
			shadow.own_node = value[4:0];
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		shadow.compare(regsel == REG_GROUP ? "group_id readback" : "own_node readback",
			64'(prdata), 64'(value));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(int count, bit clears, bit fill);
		for (int i = 0; i < count; i++)
			send_item(random_pkt(clears, fill));
	endtask

	initial begin : stimulus
		packet_t p;
		shadow = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: group 1, node 1
		p = make_pkt(MODE_PKT, 16'd1, MSG_DISCOVER, 8'hFF, 8'd200, 8'd0);
		p.req = 8'hFF;
		send_item(p);
		send_item(make_pkt(MODE_PKT, 16'hFFFF, MSG_DISCOVER, 8'd3, 8'd1, 8'd0));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_DISC_ANS, 8'd7, 8'd1, 8'd0));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_DISC_ANS, 8'd7, 8'd1, 8'd0));
		// receiver bits above the node width must not match
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_DISC_ANS, 8'd9, 8'h21, 8'd0));
		p = make_pkt(MODE_PKT, 16'd1, MSG_CREATE, 8'd2, 8'd1, 8'd0);
		p.lo = '1;
		p.mid = '1;
		p.hi = '1;
		send_item(p);
		p = make_pkt(MODE_PKT, 16'd1, MSG_CREATE, 8'd0, 8'd1, 8'd0);
		p.req = 8'd0;
		p.lo = '0;
		p.mid = '0;
		p.hi = '0;
		send_item(p);
		send_item(make_pkt(MODE_PKT, 16'h8001, MSG_CREATE, 8'd2, 8'd1, 8'd0));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_CREATE, 8'd2, 8'h81, 8'd0));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_RETRIEVE, 8'd4, 8'd1, 8'd0));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_RETRIEVE, 8'd4, 8'd1, 8'd1));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_RETRIEVE, 8'd4, 8'd1, 8'd2));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_RETRIEVE, 8'd4, 8'd1, 8'd64));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_RETRIEVE, 8'd4, 8'd1, 8'hFF));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_DELETE, 8'd5, 8'd1, 8'd0));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_DELETE, 8'd5, 8'd1, 8'd0));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_DELETE, 8'd5, 8'd1, 8'd64));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_DELETE, 8'd5, 8'd1, 8'hFF));
		// freed slot 0 is reused first
		p = make_pkt(MODE_PKT, 16'd1, MSG_CREATE, 8'd6, 8'd1, 8'd0);
		p.lo = 64'hAAAA_AAAA_AAAA_AAAA;
		p.mid = 64'h5555_5555_5555_5555;
		p.hi = 24'hA5A5A5;
		send_item(p);
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_RETRIEVE, 8'd6, 8'd1, 8'd0));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_FIRST_UNKNOWN, 8'd6, 8'd1, 8'd0));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_LAST_UNKNOWN, 8'd6, 8'd1, 8'd0));
		send_item(make_pkt(MODE_CLR_STORE, 16'd1, MSG_CREATE, 8'd6, 8'd1, 8'd0));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_RETRIEVE, 8'd8, 8'd1, 8'd1));
		send_item(make_pkt(MODE_CLR_NBR, 16'd1, MSG_CREATE, 8'd6, 8'd1, 8'd0));
		send_item(make_pkt(MODE_PKT, 16'd1, MSG_DISCOVER, 8'd0, 8'd1, 8'd0));
		send_item(make_pkt(MODE_UNUSED, 16'd1, MSG_CREATE, 8'd6, 8'd1, 8'd0));
		wait_idle();

		// fill the store and the neighbor list
		run_random(PHASE_ITEMS, 1'b0, 1'b1);
		wait_idle();

		write_reg(REG_GROUP, 32'hFFFF);
		write_reg(REG_NODE, 32'd25);
		choke_req = 1'b1;
		run_random(PHASE_ITEMS, 1'b1, 1'b0);
		wait_idle();

		write_reg(REG_GROUP, 32'($urandom_range(2, 16'hFFFE)));
		write_reg(REG_NODE, 32'($urandom_range(2, MAX_NODE - 1)));
		calm = 1'b1;
		run_random(PHASE_ITEMS, 1'b1, 1'b0);
		calm = 1'b0;
		wait_idle();

		write_reg(REG_GROUP, 32'd1);
		write_reg(REG_NODE, 32'd25);
		run_random(PHASE_ITEMS, 1'b1, 1'b0);
		wait_idle();

		write_reg(REG_GROUP, 32'hFFFF);
		write_reg(REG_NODE, 32'd1);
		run_random(PHASE_ITEMS, 1'b0, 1'b1);
		wait_idle();

		write_reg(REG_GROUP, 32'h5A5A);
		write_reg(REG_NODE, 32'd14);
		run_random(PHASE_ITEMS, 1'b1, 1'b0);
		wait_idle();

		if (shadow.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
